FILE: sv/snow_vi_keystream_cipher_defines.svh
// Assertion macros shared by the checker.
`ifndef SNOW_VI_KEYSTREAM_CIPHER_DEFINES_SVH
`define SNOW_VI_KEYSTREAM_CIPHER_DEFINES_SVH

`define SNV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SNV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/snv_pkg.sv
`default_nettype none
package snv_pkg;
    localparam int unsigned InitRounds = 16;
    localparam logic [15:0] PolyA = 16'h4a6d;
    localparam logic [15:0] PolyB = 16'hcc87;
    localparam logic [127:0] SigmaSel = {64'h0f0b07030e0a0602, 64'h0d0905010c080400};
    localparam logic CmdInit = 1'b0;
    localparam logic CmdData = 1'b1;
    localparam logic [2:0] CfgKey0 = 3'd0;
    localparam logic [2:0] CfgKey1 = 3'd1;
    localparam logic [2:0] CfgKey2 = 3'd2;
    localparam logic [2:0] CfgKey3 = 3'd3;
    localparam logic [2:0] CfgIvLo = 3'd4;
    localparam logic [2:0] CfgIvHi = 3'd5;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_INIT,
        t_ST_DATA,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic start_init;
        logic step;
        logic feedback;
        logic key_lo;
        logic key_hi;
    } t_ctrl;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = xt(x);
        end
        gmul = r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] p;
        logic [7:0] s;
        r = 8'h01;
        p = v;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, p);
            p = gmul(p, p);
        end
        s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]};
        sbox = s ^ 8'h63;
    endfunction
endpackage
`default_nettype wire

FILE: sv/snv_aes_unit.sv
`default_nettype none
module snv_aes_unit (
    input  wire logic [127:0] i_a,
    input  wire logic [127:0] i_k,
    output logic [127:0]      o_q
);
    logic [7:0] w_t [16];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_t[r + 4 * c] = snv_pkg::sbox(i_a[8 * (r + 4 * ((c + r) % 4)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            o_q[8 * (4 * c) +: 8] = snv_pkg::xt(w_t[4 * c]) ^ snv_pkg::xt(w_t[4 * c + 1])
                ^ w_t[4 * c + 1] ^ w_t[4 * c + 2] ^ w_t[4 * c + 3] ^ i_k[8 * (4 * c) +: 8];
            o_q[8 * (4 * c + 1) +: 8] = w_t[4 * c] ^ snv_pkg::xt(w_t[4 * c + 1])
                ^ snv_pkg::xt(w_t[4 * c + 2]) ^ w_t[4 * c + 2] ^ w_t[4 * c + 3]
                ^ i_k[8 * (4 * c + 1) +: 8];
            o_q[8 * (4 * c + 2) +: 8] = w_t[4 * c] ^ w_t[4 * c + 1]
                ^ snv_pkg::xt(w_t[4 * c + 2]) ^ snv_pkg::xt(w_t[4 * c + 3]) ^ w_t[4 * c + 3]
                ^ i_k[8 * (4 * c + 2) +: 8];
            o_q[8 * (4 * c + 3) +: 8] = snv_pkg::xt(w_t[4 * c]) ^ w_t[4 * c] ^ w_t[4 * c + 1]
                ^ w_t[4 * c + 2] ^ snv_pkg::xt(w_t[4 * c + 3]) ^ i_k[8 * (4 * c + 3) +: 8];
        end
    end
endmodule
`default_nettype wire

FILE: sv/snv_round.sv
`default_nettype none
module snv_round (
    input  wire logic          i_clk,
    input  wire snv_pkg::t_ctrl i_ctrl,
    input  wire logic [255:0]  i_key,
    input  wire logic [127:0]  i_iv,
    output logic [127:0]       o_z
);
    logic [127:0] r_a0, r_a1, r_b0, r_b1, r_r1, r_r2, r_r3;
    logic [127:0] w_na, w_nb, w_a1, w_t2, w_sig, w_q3, w_q2, w_r1k;
    logic [15:0] w_tap, w_x, w_y;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_tap = (j == 0) ? r_a0[127:112] : r_a1[16 * (j - 1) +: 16];
            w_x = r_a0[16 * j +: 16];
            w_y = r_b0[16 * j +: 16];
            w_na[16 * j +: 16] = w_tap ^ w_y ^ (w_x[15] ? snv_pkg::PolyA : 16'h0)
                ^ {w_x[14:0], 1'b0};
            w_nb[16 * j +: 16] = r_b1[16 * j +: 16] ^ (w_y[15] ? snv_pkg::PolyB : 16'h0)
                ^ w_x ^ {w_y[14:0], 1'b0};
        end
        for (int i = 0; i < 4; i++) begin
            o_z[32 * i +: 32] = (r_b1[32 * i +: 32] + r_r1[32 * i +: 32]) ^ r_r2[32 * i +: 32];
            w_t2[32 * i +: 32] = r_r2[32 * i +: 32] + r_r3[32 * i +: 32];
        end
        w_a1 = i_ctrl.feedback ? (w_na ^ o_z) : w_na;
        for (int i = 0; i < 16; i++) begin
            w_sig[8 * i +: 8] = w_t2[8 * 32'(snv_pkg::SigmaSel[8 * i +: 4]) +: 8];
        end
        w_r1k = w_sig;
        if (i_ctrl.key_lo) w_r1k = w_sig ^ i_key[127:0];
        if (i_ctrl.key_hi) w_r1k = w_sig ^ i_key[255:128];
    end

    snv_aes_unit u_aes3 (.i_a(r_r2), .i_k(w_a1), .o_q(w_q3));
    snv_aes_unit u_aes2 (.i_a(r_r1), .i_k(128'h0), .o_q(w_q2));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start_init) begin
            r_a0 <= i_iv;
            r_a1 <= i_key[127:0];
            r_b0 <= 128'h0;
            r_b1 <= i_key[255:128];
            r_r1 <= 128'h0;
            r_r2 <= 128'h0;
            r_r3 <= i_key[127:0];
        end else if (i_ctrl.step) begin
            r_a0 <= r_a1;
            r_a1 <= w_a1;
            r_b0 <= r_b1;
            r_b1 <= w_nb;
            r_r1 <= w_r1k;
            r_r2 <= w_q2;
            r_r3 <= w_q3;
        end
    end
endmodule
`default_nettype wire

FILE: sv/snow_vi_keystream_cipher.sv
// Init transfer: the accepting edge loads key and IV, then 16 rounds of the shared round unit
// run in the INIT state before the next acceptance; no output.
// Data transfer: the DATA state steps the round unit and registers the result, shown in OUT.
// A new block is accepted only in IDLE, after the previous result has been taken.
// Synchronous active-low reset clears control and the configuration registers;
// the cipher state is zeroed by a zero load when a data command comes before any init.
`default_nettype none
module snow_vi_keystream_cipher (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // text_lo, text_hi
    input  wire logic         s_axis_tuser,  // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // result_lo, result_hi
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    snv_pkg::t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [63:0] r_cfg [6];
    logic [127:0] r_text, r_out;
    logic r_zero;
    snv_pkg::t_ctrl w_ctrl;
    logic [127:0] w_z;
    logic w_zero_load;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == snv_pkg::t_ST_IDLE);
    assign m_axis_tvalid = (r_state == snv_pkg::t_ST_OUT);
    assign m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_cfg[i] <= 64'h0;
        end else if (i_cfg_valid && i_cfg_index <= snv_pkg::CfgIvHi) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snv_pkg::t_ST_IDLE;
            r_cnt <= 5'd0;
            r_zero <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            if (w_ctrl.start_init) r_zero <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_text <= s_axis_tdata;
        if (r_state == snv_pkg::t_ST_DATA) r_out <= w_z ^ r_text;
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        w_ctrl = '0;
        case (r_state)
            snv_pkg::t_ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cnt = 5'd0;
                    if (s_axis_tuser == snv_pkg::CmdInit) begin
                        w_ctrl.start_init = 1'b1;
                        n_state = snv_pkg::t_ST_INIT;
                    end else begin
                        w_ctrl.start_init = r_zero;
                        n_state = snv_pkg::t_ST_DATA;
                    end
                end
            end
            snv_pkg::t_ST_INIT: begin
                w_ctrl.step = 1'b1;
                w_ctrl.feedback = 1'b1;
                w_ctrl.key_lo = (r_cnt == 5'(snv_pkg::InitRounds - 2));
                w_ctrl.key_hi = (r_cnt == 5'(snv_pkg::InitRounds - 1));
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(snv_pkg::InitRounds - 1)) n_state = snv_pkg::t_ST_IDLE;
            end
            snv_pkg::t_ST_DATA: begin
                w_ctrl.step = 1'b1;
                n_state = snv_pkg::t_ST_OUT;
            end
            snv_pkg::t_ST_OUT: begin
                if (m_axis_tready) n_state = snv_pkg::t_ST_IDLE;
            end
            default: n_state = snv_pkg::t_ST_IDLE;
        endcase
    end

    // Before any init the state must read as zero; a forced load with zero key does that.
    logic [255:0] w_key;
    logic [127:0] w_iv;
    assign w_zero_load = r_zero && (s_axis_tuser == snv_pkg::CmdData);
    assign w_key = w_zero_load ? 256'h0 : {r_cfg[snv_pkg::CfgKey3], r_cfg[snv_pkg::CfgKey2],
                                           r_cfg[snv_pkg::CfgKey1], r_cfg[snv_pkg::CfgKey0]};
    assign w_iv = w_zero_load ? 128'h0 : {r_cfg[snv_pkg::CfgIvHi], r_cfg[snv_pkg::CfgIvLo]};

    snv_round u_round (
        .i_clk (i_clk),
        .i_ctrl(w_ctrl),
        .i_key (w_key),
        .i_iv  (w_iv),
        .o_z   (w_z)
    );
endmodule
`default_nettype wire

FILE: sv/snv_checker.sv
`default_nettype none
`include "snow_vi_keystream_cipher_defines.svh"
module snv_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);
    `SNV_ASSERT_IMPL(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SNV_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SNV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `SNV_ASSERT_NEXT(a_noout, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && !s_axis_tuser, !m_axis_tvalid)
endmodule

bind snow_vi_keystream_cipher snv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: bench/tb_snow_vi_keystream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_snow_vi_keystream_cipher;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    snow_vi_keystream_cipher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct {
        logic         cmd;
        logic [127:0] text;
        logic         known;
        logic [127:0] want;
    } t_vec;

    logic [63:0]  key_iv [6];
    logic [127:0] a_lo, a_hi, b_lo, b_hi, r1, r2, r3;
    logic [127:0] block_queue [$];
    int           errors;
    logic         calm;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] ff_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] v);
        logic [7:0] inv, p, s;
        inv = 8'h01;
        p = v;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) inv = ff_mul(inv, p);
            p = ff_mul(p, p);
        end
        s = inv;
        for (int n = 1; n <= 4; n++) s ^= (inv << n) | (inv >> (8 - n));
        return s ^ 8'h63;
    endfunction

    function automatic logic [127:0] aes_enc(input logic [127:0] st, input logic [127:0] rk);
        logic [7:0] t [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4 * c] = sub_byte(st[8 * (r + 4 * ((c + r) % 4)) +: 8]);
        for (int c = 0; c < 4; c++) begin
            o[8 * (4 * c) +: 8] = ff_mul(t[4 * c], 8'h02) ^ ff_mul(t[4 * c + 1], 8'h03)
                ^ t[4 * c + 2] ^ t[4 * c + 3];
            o[8 * (4 * c + 1) +: 8] = t[4 * c] ^ ff_mul(t[4 * c + 1], 8'h02)
                ^ ff_mul(t[4 * c + 2], 8'h03) ^ t[4 * c + 3];
            o[8 * (4 * c + 2) +: 8] = t[4 * c] ^ t[4 * c + 1]
                ^ ff_mul(t[4 * c + 2], 8'h02) ^ ff_mul(t[4 * c + 3], 8'h03);
            o[8 * (4 * c + 3) +: 8] = ff_mul(t[4 * c], 8'h03) ^ t[4 * c + 1]
                ^ t[4 * c + 2] ^ ff_mul(t[4 * c + 3], 8'h02);
        end
        return o ^ rk;
    endfunction

    function automatic logic [127:0] lane_add(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] o;
        for (int i = 0; i < 4; i++) o[32 * i +: 32] = x[32 * i +: 32] + y[32 * i +: 32];
        return o;
    endfunction

    function automatic logic [127:0] cipher_round(input logic feed, input logic [127:0] text);
        logic [127:0] na, nb, z, t2, sel;
        logic [15:0] tap, x, y;
        sel = snv_pkg::SigmaSel;
        for (int j = 0; j < 8; j++) begin
            tap = (j == 0) ? a_lo[112 +: 16] : a_hi[16 * (j - 1) +: 16];
            x = a_lo[16 * j +: 16];
            y = b_lo[16 * j +: 16];
            na[16 * j +: 16] = tap ^ y ^ (x[15] ? snv_pkg::PolyA : 16'h0) ^ {x[14:0], 1'b0};
            nb[16 * j +: 16] = b_hi[16 * j +: 16] ^ (y[15] ? snv_pkg::PolyB : 16'h0) ^ x
                ^ {y[14:0], 1'b0};
        end
        z = lane_add(b_hi, r1) ^ r2;
        a_lo = a_hi;
        b_lo = b_hi;
        a_hi = feed ? (na ^ z) : na;
        b_hi = nb;
        t2 = lane_add(r2, r3);
        r3 = aes_enc(r2, a_hi);
        r2 = aes_enc(r1, 128'h0);
        for (int i = 0; i < 16; i++) r1[8 * i +: 8] = t2[8 * sel[8 * i +: 4] +: 8];
        return z ^ text;
    endfunction

    function automatic void predict_block(input logic cmd, input logic [127:0] text);
        if (cmd == snv_pkg::CmdInit) begin
            a_lo = {key_iv[snv_pkg::CfgIvHi], key_iv[snv_pkg::CfgIvLo]};
            a_hi = {key_iv[snv_pkg::CfgKey1], key_iv[snv_pkg::CfgKey0]};
            b_lo = '0;
            b_hi = {key_iv[snv_pkg::CfgKey3], key_iv[snv_pkg::CfgKey2]};
            r1 = '0;
            r2 = '0;
            r3 = {key_iv[snv_pkg::CfgKey1], key_iv[snv_pkg::CfgKey0]};
            for (int i = 0; i < snv_pkg::InitRounds; i++) begin
                void'(cipher_round(1'b1, '0));
                if (i == snv_pkg::InitRounds - 2)
                    r1 ^= {key_iv[snv_pkg::CfgKey1], key_iv[snv_pkg::CfgKey0]};
                if (i == snv_pkg::InitRounds - 1)
                    r1 ^= {key_iv[snv_pkg::CfgKey3], key_iv[snv_pkg::CfgKey2]};
            end
        end else begin
            block_queue.push_back(cipher_round(1'b0, text));
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [127:0] got,
                                   input logic [127:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (block_queue.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata[63:0] !== block_queue[0][63:0])
                    report_mismatch("result_lo", m_axis_tdata[63:0], block_queue[0][63:0]);
                if (m_axis_tdata[127:64] !== block_queue[0][127:64])
                    report_mismatch("result_hi", m_axis_tdata[127:64], block_queue[0][127:64]);
                void'(block_queue.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < 6) key_iv[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input logic cmd, input logic [127:0] text);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= text;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_block(cmd, text);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (block_queue.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    initial begin
        #40_000_000;
        $display("[snow_vi_keystream_cipher] ERROR");
        $finish;
    end

    initial begin
        t_vec vecs [$];
        t_vec v;
        logic [127:0] txt;
        errors = 0;
        calm = 1'b0;
        for (int i = 0; i < 6; i++) key_iv[i] = '0;
        a_lo = '0; a_hi = '0; b_lo = '0; b_hi = '0; r1 = '0; r2 = '0; r3 = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = snv_pkg::CmdData;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = snv_pkg::CfgKey0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The all-zero state gives an all-zero keystream, so the text comes back.
        vecs.push_back('{snv_pkg::CmdData, '0, 1'b1, '0});
        vecs.push_back('{snv_pkg::CmdData, {128{1'b1}}, 1'b0, '0});
        vecs.push_back('{snv_pkg::CmdInit, {128{1'b1}}, 1'b0, '0});
        vecs.push_back('{snv_pkg::CmdData, '0, 1'b0, '0});
        vecs.push_back('{snv_pkg::CmdData, {128{1'b1}}, 1'b0, '0});
        vecs.push_back('{snv_pkg::CmdData, 128'h8000_0000_0000_0001_8000_0000_0000_0001,
                         1'b0, '0});
        foreach (vecs[i]) begin
            send_block(vecs[i].cmd, vecs[i].text);
            if (vecs[i].known && block_queue[$] !== vecs[i].want)
                report_mismatch("directed prediction", block_queue[$], vecs[i].want);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 6; r++) begin
                case (ph)
                    0: write_reg(3'(r), '1);
                    1: write_reg(3'(r), 64'h0);
                    default: write_reg(3'(r), rand64());
                endcase
            end
            write_reg(3'd6 + 3'(ph % 2), rand64());
            calm = (ph == 3);
            send_block(snv_pkg::CmdInit, {rand64(), rand64()});
            for (int k = 0; k < 215; k++) begin
                if ($urandom_range(99) < 2) begin
                    send_block(snv_pkg::CmdInit, {rand64(), rand64()});
                end else begin
                    txt = {rand64(), rand64()};
                    if ($urandom_range(9) == 0) txt = ($urandom_range(1) != 0) ? '1 : '0;
                    send_block(snv_pkg::CmdData, txt);
                end
                if (k == 100) begin
                    while (block_queue.size() != 0) @(negedge i_clk);
                end
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("[snow_vi_keystream_cipher] OK");
        end else begin
            $display("[snow_vi_keystream_cipher] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
